/* src/scb_pkg.sv */
`default_nettype none
package scb_pkg;

    localparam int unsigned W         = 32;
    localparam int unsigned DIV_STEPS = 32;
    // prep stages + divider setup + divider steps + output register
    localparam int unsigned LATENCY   = 3 + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic          hit;
        logic          div_y;   // divided axis is y, x takes other
        logic          neg_x;
        logic          neg_y;
        logic [W-1:0]  other;
        logic [W-1:0]  raw_x;
        logic [W-1:0]  raw_y;
    } t_side;

endpackage
`default_nettype wire

/* src/scb_prep.sv */
`default_nettype none
module scb_prep (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_vld,
    input  wire logic signed [31:0]       i_ml,
    input  wire logic signed [31:0]       i_mr,
    input  wire logic signed [31:0]       i_mb,
    input  wire logic signed [31:0]       i_mt,
    input  wire logic signed [31:0]       i_ol,
    input  wire logic signed [31:0]       i_or,
    input  wire logic signed [31:0]       i_ob,
    input  wire logic signed [31:0]       i_ot,
    input  wire logic signed [31:0]       i_dx,
    input  wire logic signed [31:0]       i_dy,
    output logic                          o_vld,
    output logic [63:0]                   o_num,
    output logic [31:0]                   o_den,
    output scb_pkg::t_side                o_side
);

    function automatic logic [31:0] gap_of(input logic signed [31:0] s1,
                                           input logic signed [31:0] e1,
                                           input logic signed [31:0] s2,
                                           input logic signed [31:0] e2);
        logic signed [32:0] d;
        d = 33'sd0;
        if (s1 > e2) begin
            d = 33'(s1) - 33'(e2);
        end else if (e1 < s2) begin
            d = 33'(s2) - 33'(e1);
        end
        return d[31:0];
    endfunction

    function automatic logic [31:0] mag_of(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // stage 1: hit test, gaps, magnitudes
    logic signed [32:0] lx, rx, by, ty;
    logic               n_hit;
    assign lx = 33'(i_ml) + 33'(i_dx);
    assign rx = 33'(i_mr) + 33'(i_dx);
    assign by = 33'(i_mb) + 33'(i_dy);
    assign ty = 33'(i_mt) + 33'(i_dy);
    assign n_hit = (lx < 33'(i_or)) && (rx > 33'(i_ol)) &&
                   (by < 33'(i_ot)) && (ty > 33'(i_ob));

    logic          r1_vld;
    logic [31:0]   r1_gx, r1_gy, r1_adx, r1_ady;
    scb_pkg::t_side r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_gx        <= gap_of(i_ml, i_mr, i_ol, i_or);
        r1_gy        <= gap_of(i_mb, i_mt, i_ob, i_ot);
        r1_adx       <= mag_of(i_dx);
        r1_ady       <= mag_of(i_dy);
        r1_side.hit   <= n_hit;
        r1_side.div_y <= 1'b0;
        r1_side.neg_x <= i_dx[31];
        r1_side.neg_y <= i_dy[31];
        r1_side.other <= '0;
        r1_side.raw_x <= i_dx;
        r1_side.raw_y <= i_dy;
    end

    // stage 2: cross products
    logic          r2_vld;
    logic [63:0]   r2_lhs, r2_rhs;
    logic [31:0]   r2_gx, r2_gy, r2_adx, r2_ady;
    scb_pkg::t_side r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_lhs  <= 64'(r1_gx) * 64'(r1_ady);
        r2_rhs  <= 64'(r1_adx) * 64'(r1_gy);
        r2_gx   <= r1_gx;
        r2_gy   <= r1_gy;
        r2_adx  <= r1_adx;
        r2_ady  <= r1_ady;
        r2_side <= r1_side;
    end

    // stage 3: pick the later-entry axis and set up the division
    logic [63:0]    n_num;
    logic [31:0]    n_den;
    scb_pkg::t_side n_side;

    always_comb begin
        n_side = r2_side;
        priority if (r2_lhs > r2_rhs) begin
            n_side.div_y = 1'b1;
            n_side.other = r2_gx;
            n_num        = r2_lhs;
            n_den        = r2_adx;
        end else if (r2_ady != 32'd0) begin
            n_side.div_y = 1'b0;
            n_side.other = r2_gy;
            n_num        = r2_rhs;
            n_den        = r2_ady;
        end else begin
            // zero dy: y clamps to zero
            n_side.div_y = 1'b1;
            n_side.other = r2_gx;
            n_num        = 64'd0;
            n_den        = 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r2_vld;
        end
        o_num  <= n_num;
        o_den  <= n_den;
        o_side <= n_side;
    end

endmodule
`default_nettype wire

/* src/scb_div.sv */
`default_nettype none
module scb_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire logic [63:0]     i_num,
    input  wire logic [31:0]     i_den,
    input  wire scb_pkg::t_side  i_side,
    output logic                 o_vld,
    output logic [31:0]          o_quo,
    output logic                 o_sat,
    output scb_pkg::t_side       o_side
);

    localparam int unsigned N = scb_pkg::DIV_STEPS;

    logic           r_vld  [0:N];
    logic [31:0]    r_rem  [0:N];
    logic [31:0]    r_lo   [0:N];   // numerator bits in, quotient bits out
    logic [31:0]    r_den  [0:N];
    logic           r_sat  [0:N];
    scb_pkg::t_side r_side [0:N];

    // setup: quotient of 2^32 or more saturates (also covers zero divisor)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_sat[0]  <= (i_num[63:32] >= i_den);
        r_rem[0]  <= i_num[63:32];
        r_lo[0]   <= i_num[31:0];
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [32:0] t;
        logic        ge;
        logic [32:0] d;
        assign t  = {r_rem[k], r_lo[k][31]};
        assign ge = (t >= {1'b0, r_den[k]});
        assign d  = t - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= ge ? d[31:0] : t[31:0];
            r_lo[k+1]   <= {r_lo[k][30:0], ge};
            r_den[k+1]  <= r_den[k];
            r_sat[k+1]  <= r_sat[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[N];
    assign o_quo  = r_lo[N];
    assign o_sat  = r_sat[N];
    assign o_side = r_side[N];

endmodule
`default_nettype wire

/* src/swept_box_collision_clamp_unit.sv */
// Pipeline: 3 prep stages, 33 divider stages and 1 output stage lie between start
// and o_done. Throughput: one beat per cycle; o_busy is always low.
// The divider resolves one quotient bit per stage over 32 stages.
// Results appear for one cycle with o_done; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits; data is not reset.
`default_nettype none
module swept_box_collision_clamp_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [31:0] i_mover_left,
    input  wire logic signed [31:0] i_mover_right,
    input  wire logic signed [31:0] i_mover_bottom,
    input  wire logic signed [31:0] i_mover_top,
    input  wire logic signed [31:0] i_obstacle_left,
    input  wire logic signed [31:0] i_obstacle_right,
    input  wire logic signed [31:0] i_obstacle_bottom,
    input  wire logic signed [31:0] i_obstacle_top,
    input  wire logic signed [31:0] i_move_x,
    input  wire logic signed [31:0] i_move_y,
    output logic                    o_done,
    output logic                    o_collide,
    output logic signed [31:0]      o_allowed_x,
    output logic signed [31:0]      o_allowed_y
);

    function automatic logic [31:0] signed_out(input logic [31:0] mag,
                                               input logic sat,
                                               input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (sat || mag[31]) ? 32'h8000_0000 : 32'(-mag);
        end else begin
            r = (sat || mag >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
        end
        return r;
    endfunction

    logic           p_vld;
    logic [63:0]    p_num;
    logic [31:0]    p_den;
    scb_pkg::t_side p_side;

    scb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_ml    (i_mover_left),
        .i_mr    (i_mover_right),
        .i_mb    (i_mover_bottom),
        .i_mt    (i_mover_top),
        .i_ol    (i_obstacle_left),
        .i_or    (i_obstacle_right),
        .i_ob    (i_obstacle_bottom),
        .i_ot    (i_obstacle_top),
        .i_dx    (i_move_x),
        .i_dy    (i_move_y),
        .o_vld   (p_vld),
        .o_num   (p_num),
        .o_den   (p_den),
        .o_side  (p_side)
    );

    logic           d_vld;
    logic [31:0]    d_quo;
    logic           d_sat;
    scb_pkg::t_side d_side;

    scb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (p_vld),
        .i_num   (p_num),
        .i_den   (p_den),
        .i_side  (p_side),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_sat   (d_sat),
        .o_side  (d_side)
    );

    logic [31:0] n_x, n_y;

    always_comb begin
        if (!d_side.hit) begin
            n_x = d_side.raw_x;
            n_y = d_side.raw_y;
        end else if (d_side.div_y) begin
            n_x = signed_out(d_side.other, 1'b0, d_side.neg_x);
            n_y = signed_out(d_quo, d_sat, d_side.neg_y);
        end else begin
            n_x = signed_out(d_quo, d_sat, d_side.neg_x);
            n_y = signed_out(d_side.other, 1'b0, d_side.neg_y);
        end
    end

    logic        r_done;
    logic        r_coll;
    logic [31:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld;
        end
        r_coll <= d_side.hit;
        r_x    <= n_x;
        r_y    <= n_y;
    end

    assign o_busy      = 1'b0;
    assign o_done      = r_done;
    assign o_collide   = r_done & r_coll;
    assign o_allowed_x = r_x;
    assign o_allowed_y = r_y;

    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, scb_pkg::LATENCY))
        else $error("result beat without a matching start");

    a_pass_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_collide) |-> (o_allowed_x == $past(i_move_x, scb_pkg::LATENCY)))
        else $error("no-hit x motion not passed through");

    a_pass_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_collide) |-> (o_allowed_y == $past(i_move_y, scb_pkg::LATENCY)))
        else $error("no-hit y motion not passed through");

endmodule
`default_nettype wire

/* sim/tb_swept_box_collision_clamp_unit.sv */
`default_nettype none
module tb_swept_box_collision_clamp_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        collide;
        logic [31:0] ax;
        logic [31:0] ay;
    } t_clamp_res;

    class clamp_scoreboard;
        t_clamp_res pending[$];
        int         n_bad;
        int         n_ok;
        int         n_hits;

        function logic [31:0] sat_signed(logic [63:0] mag, bit neg);
            logic [31:0] r;
            if (neg) begin
                r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
            end else begin
                r = (mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
            return r;
        endfunction

        function logic [63:0] axis_gap(longint s1, longint e1, longint s2, longint e2);
            logic [63:0] g;
            if (s1 > e2) g = s1 - e2;
            else if (e1 < s2) g = s2 - e1;
            else g = '0;
            return g;
        endfunction

        function void note_pair(logic signed [31:0] f[10]);
            longint      ml, mr, mb, mt, ol, orr, ob, ot, dx, dy;
            logic [63:0] gx, gy, adx, ady, lhs, rhs, ax, ay;
            t_clamp_res  e;
            ml = f[0]; mr = f[1]; mb = f[2]; mt = f[3];
            ol = f[4]; orr = f[5]; ob = f[6]; ot = f[7];
            dx = f[8]; dy = f[9];
            if (!((ml + dx) < orr && (mr + dx) > ol && (mb + dy) < ot && (mt + dy) > ob)) begin
                e.collide = 1'b0;
                e.ax = f[8];
                e.ay = f[9];
            end else begin
                gx = axis_gap(ml, mr, ol, orr);
                gy = axis_gap(mb, mt, ob, ot);
                adx = dx < 0 ? -dx : dx;
                ady = dy < 0 ? -dy : dy;
                lhs = gx * ady;
                rhs = adx * gy;
                if (lhs > rhs) begin
                    ax = gx;
                    ay = adx != 0 ? lhs / adx : '1;
                end else if (ady > 0) begin
                    ax = rhs / ady;
                    ay = gy;
                end else begin
                    ax = gx;
                    ay = '0;
                end
                e.collide = 1'b1;
                e.ax = sat_signed(ax, dx < 0);
                e.ay = sat_signed(ay, dy < 0);
                n_hits++;
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic c, logic [31:0] ax, logic [31:0] ay);
            t_clamp_res e;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result beat c=%0b x=%h y=%h", c, ax, ay);
                return;
            end
            e = pending.pop_front();
            if (c !== e.collide || ax !== e.ax || ay !== e.ay) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp c=%0b x=%h y=%h got c=%0b x=%h y=%h",
                             e.collide, e.ax, e.ay, c, ax, ay);
            end else begin
                n_ok++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic signed [31:0] fld[10];
    wire               o_busy, o_done, o_collide;
    wire signed [31:0] o_allowed_x, o_allowed_y;

    clamp_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned n_sent = 0;

    swept_box_collision_clamp_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mover_left(fld[0]), .i_mover_right(fld[1]),
        .i_mover_bottom(fld[2]), .i_mover_top(fld[3]),
        .i_obstacle_left(fld[4]), .i_obstacle_right(fld[5]),
        .i_obstacle_bottom(fld[6]), .i_obstacle_top(fld[7]),
        .i_move_x(fld[8]), .i_move_y(fld[9]),
        .o_done(o_done), .o_collide(o_collide),
        .o_allowed_x(o_allowed_x), .o_allowed_y(o_allowed_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) sb.check_result(o_collide, o_allowed_x, o_allowed_y);
        if (cycles > 200000) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        foreach (fld[i]) fld[i] = '0;
    end

    // one beat: present at falling edge, hold until accepted
    task automatic send_pair(logic signed [31:0] v[10]);
        fld = v;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_pair(v);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle(int n);
        i_start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_coord(int mode);
        logic signed [31:0] r;
        case (mode)
            0: r = $urandom;
            1: r = $signed($urandom_range(0, 2000)) - 1000;
            2: r = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: r = ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                         ^ $urandom_range(0, 15);
        endcase
        return r;
    endfunction

    // a pair that mostly collides: obstacle near mover shifted by move
    // x axis fills slots 0,1,4,5,8 and y axis slots 2,3,6,7,9
    task automatic make_pair(output logic signed [31:0] v[10]);
        int m, k;
        logic signed [31:0] w, h;
        m = $urandom_range(0, 9) < 6 ? $urandom_range(1, 2) : $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 7) begin
            for (k = 0; k < 2; k++) begin
                w = $urandom_range(1, m == 1 ? 300 : 32'h0010_0000);
                h = $urandom_range(1, m == 1 ? 300 : 32'h0010_0000);
                v[k*2]   = rnd_coord(m == 3 ? 1 : m);
                v[k*2+1] = v[k*2] + w;
                v[4+k*2] = v[k*2] + $signed($urandom_range(0, 2*w+2*h)) - w - h;
                v[5+k*2] = v[4+k*2] + h;
                v[8+k]   = $urandom_range(0, 7) == 0 ? 0 :
                           $signed($urandom_range(0, 4*(w+h))) - 2*(w+h);
            end
        end else begin
            foreach (v[i]) v[i] = rnd_coord(m);
        end
    endtask

    initial begin
        logic signed [31:0] v[10];
        int burst;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: touching, overlap, zero moves, extremes, reversed edges
        send_pair('{0, 10, 0, 10, 10, 20, 0, 10, 0, 0});
        send_pair('{0, 10, 0, 10, 20, 30, 0, 10, 10, 0});
        send_pair('{0, 10, 0, 10, 20, 30, 0, 10, 15, 0});
        send_pair('{0, 10, 0, 10, 20, 30, 20, 30, 15, 15});
        send_pair('{0, 10, 0, 10, 20, 30, 15, 30, 20, 14});
        send_pair('{0, 10, 0, 10, -30, -20, -30, -20, -15, -15});
        send_pair('{0, 10, 0, 10, 5, 8, 5, 8, 0, 0});
        send_pair('{0, 10, 0, 10, 5, 8, 20, 30, 0, 15});
        send_pair('{0, 10, 0, 10, 5, 8, -30, -20, 0, -15});
        send_pair('{0, 10, 0, 10, 20, 30, 5, 8, 15, 0});
        send_pair('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh8000_0000});
        send_pair('{32'sh8000_0000, 32'sh8000_0001, 32'sh8000_0000, 32'sh8000_0001,
                    32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        send_pair('{32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh8000_0001, 32'sh8000_0000, 32'sh8000_0001,
                    32'sh8000_0000, 32'sh8000_0000});
        send_pair('{10, 0, 10, 0, 5, 8, 5, 8, 1, 1});
        send_pair('{0, 10, 0, 10, 3, 2, 3, 2, 0, 0});
        send_pair('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});

        while (n_sent < 1050) begin
            burst = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
            repeat (burst) begin
                make_pair(v);
                send_pair(v);
            end
            idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        end
        i_start = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (scb_pkg::LATENCY + 5) @(posedge i_clk);

        $display("%0d pairs sent, %0d results matched, %0d with a hit",
                 n_sent, sb.n_ok, sb.n_hits);
        if (sb.n_bad == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", sb.n_bad);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
